FILE: rtl/core/nmsf_pkg.sv
// nmsf_pkg: opcodes, character codes and the hex digit helper for the nmea sentence framer
// no dependencies; compiled first
package nmsf_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [1:0] t_opcode;

    localparam t_opcode OP_PUSH  = 2'd0;
    localparam t_opcode OP_READ  = 2'd1;
    localparam t_opcode OP_CLEAR = 2'd2;

    localparam t_byte CH_DOLLAR = 8'h24;
    localparam t_byte CH_STAR   = 8'h2A;
    localparam t_byte CH_NL     = 8'h0A;
    localparam t_byte CH_NUL    = 8'h00;

    // upper-case ascii hex digit of a nibble
    function automatic t_byte hex_ascii(input logic [3:0] v);
        t_byte r;
        if (v < 4'd10) begin
            r = 8'h30 + {4'h0, v};
        end else begin
            r = 8'h37 + {4'h0, v};
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/nmsf_if.sv
// nmsf_in_if / nmsf_out_if: valid/ready channels carrying commands and results
// depends on nmsf_pkg
interface nmsf_in_if;
    import nmsf_pkg::*;

    logic      valid;
    logic      ready;
    t_opcode   opcode;
    t_byte     data_byte;
    logic [6:0] read_index;

    modport source (output valid, opcode, data_byte, read_index, input ready);
    modport sink   (input valid, opcode, data_byte, read_index, output ready);
endinterface

interface nmsf_out_if;
    import nmsf_pkg::*;

    logic       valid;
    logic       ready;
    logic       frame_found;
    logic [6:0] frame_start;
    logic [7:0] frame_length;
    t_byte      read_data;

    modport source (output valid, frame_found, frame_start, frame_length, read_data,
                    input ready);
    modport sink   (input valid, frame_found, frame_start, frame_length, read_data,
                    output ready);
endinterface

FILE: rtl/core/nmsf_ram.sv
// nmsf_ram: generic single write port, single read port ram with registered read
// no dependencies
module nmsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/core/nmea_sentence_framer.sv
// nmea_sentence_framer: a read passes through S_RDWAIT to S_FINISH and a scanner reset goes
// straight to S_FINISH; a push rescans bytes through S_ITER and S_CHAR, walks the checksum in
// S_WCHK, checks the digits in S_D1 and S_D2 and moves bytes in S_MOVE when the store fills.
// one item is in work at a time, so a new item is taken only once the last result has left
// S_FINISH; every byte read goes through the single read port of the frame store. synchronous
// active-low reset clears the scanner; the store keeps its contents and needs no clearing pass.
module nmea_sentence_framer #(
    parameter int STORE_DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nmsf_in_if.sink     i_in_ch,
    nmsf_out_if.source  o_out_ch
);
    import nmsf_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ITER   = 4'd1;
    localparam logic [3:0] S_CHAR   = 4'd2;
    localparam logic [3:0] S_WCHK   = 4'd3;
    localparam logic [3:0] S_D1     = 4'd4;
    localparam logic [3:0] S_D2     = 4'd5;
    localparam logic [3:0] S_MOVE   = 4'd6;
    localparam logic [3:0] S_RDWAIT = 4'd7;
    localparam logic [3:0] S_FINISH = 4'd8;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_scan, n_scan;
    logic [AW-1:0] r_hdr, n_hdr;
    logic          r_inp, n_inp;
    logic          r_taken, n_taken;
    t_byte         r_byte, n_byte;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_len, n_len;
    t_byte         r_sum, n_sum;
    logic          r_ok, n_ok;
    logic [CW-1:0] r_mi, n_mi;
    logic          r_rd_sel, n_rd_sel;
    logic          r_fwd, n_fwd;
    t_byte         r_fwd_data, n_fwd_data;
    logic          r_res_found, n_res_found;
    logic [6:0]    r_res_start, n_res_start;
    logic [7:0]    r_res_len, n_res_len;
    t_byte         r_res_rdata, n_res_rdata;
    logic          r_out_valid, n_out_valid;
    logic          r_out_found, n_out_found;
    logic [6:0]    r_out_start, n_out_start;
    logic [7:0]    r_out_len, n_out_len;
    t_byte         r_out_rdata, n_out_rdata;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    t_byte         ram_wdata, ram_rdata, rd_eff;

    logic [CW-1:0] c_fill, c_scan, len_c, k1;
    logic [AW-1:0] c_hdr;
    logic          c_inp, c_take, c_taken, c_busy;

    nmsf_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // read issued in the same cycle as a write to that entry sees the new byte
    assign n_fwd      = ram_we && ram_re && (ram_waddr == ram_raddr);
    assign n_fwd_data = ram_wdata;
    assign rd_eff     = r_fwd ? r_fwd_data : ram_rdata;

    assign i_in_ch.ready         = (r_state == S_IDLE);
    assign o_out_ch.valid        = r_out_valid;
    assign o_out_ch.frame_found  = r_out_found;
    assign o_out_ch.frame_start  = r_out_start;
    assign o_out_ch.frame_length = r_out_len;
    assign o_out_ch.read_data    = r_out_rdata;

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_scan      = r_scan;
        n_hdr       = r_hdr;
        n_inp       = r_inp;
        n_taken     = r_taken;
        n_byte      = r_byte;
        n_k         = r_k;
        n_len       = r_len;
        n_sum       = r_sum;
        n_ok        = r_ok;
        n_mi        = r_mi;
        n_rd_sel    = r_rd_sel;
        n_res_found = r_res_found;
        n_res_start = r_res_start;
        n_res_len   = r_res_len;
        n_res_rdata = r_res_rdata;
        n_out_valid = r_out_valid && !o_out_ch.ready;
        n_out_found = r_out_found;
        n_out_start = r_out_start;
        n_out_len   = r_out_len;
        n_out_rdata = r_out_rdata;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = CH_NUL;
        ram_re      = 1'b0;
        ram_raddr   = '0;
        c_fill      = r_fill;
        c_scan      = r_scan;
        c_hdr       = r_hdr;
        c_inp       = r_inp;
        c_take      = 1'b0;
        c_taken     = r_taken;
        c_busy      = 1'b0;
        len_c       = '0;
        k1          = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_ch.valid) begin
                    n_res_found = 1'b0;
                    n_res_start = '0;
                    n_res_len   = '0;
                    n_res_rdata = CH_NUL;
                    n_byte      = i_in_ch.data_byte;
                    n_taken     = 1'b0;
                    case (i_in_ch.opcode)
                        OP_PUSH: begin
                            n_state = S_ITER;
                        end
                        OP_READ: begin
                            n_rd_sel = (int'(i_in_ch.read_index) < STORE_DEPTH);
                            ram_re    = 1'b1;
                            ram_raddr = AW'(i_in_ch.read_index);
                            n_state   = S_RDWAIT;
                        end
                        OP_CLEAR: begin
                            n_fill  = '0;
                            n_scan  = '0;
                            n_hdr   = '0;
                            n_inp   = 1'b0;
                            n_state = S_FINISH;
                        end
                        default: begin
                            n_state = S_FINISH;
                        end
                    endcase
                end
            end

            S_RDWAIT: begin
                n_res_rdata = r_rd_sel ? rd_eff : CH_NUL;
                n_state     = S_FINISH;
            end

            S_ITER: begin
                if (r_fill > DEPTH_C || r_scan > r_fill || {1'b0, r_hdr} >= DEPTH_C) begin
                    c_fill = '0;
                    c_scan = '0;
                    c_hdr  = '0;
                    c_inp  = 1'b0;
                end
                c_take = !r_taken && (c_scan == c_fill) && (c_fill < DEPTH_C);
                if (c_take) begin
                    ram_we    = 1'b1;
                    ram_waddr = c_scan[AW-1:0];
                    ram_wdata = r_byte;
                    c_fill    = c_fill + CW'(1);
                end
                c_taken = r_taken || c_take;

                if (!c_inp) begin
                    if (c_fill == DEPTH_C) begin
                        // full while hunting for a header: drop everything
                        c_scan = '0;
                        c_fill = '0;
                    end else if (c_scan >= c_fill) begin
                        c_fill = '0;
                        c_scan = '0;
                        c_hdr  = '0;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = c_scan[AW-1:0];
                        c_busy    = 1'b1;
                        n_state   = S_CHAR;
                    end
                end else begin
                    if (c_fill == DEPTH_C) begin
                        if (c_hdr == '0) begin
                            c_scan = CW'(1);
                            c_inp  = 1'b0;
                        end else if ({1'b0, c_hdr} > c_scan) begin
                            c_fill = '0;
                            c_scan = '0;
                            c_hdr  = '0;
                            c_inp  = 1'b0;
                        end else begin
                            // shift the open frame down to the start of the store
                            c_fill    = c_fill - {1'b0, c_hdr};
                            c_scan    = c_scan - {1'b0, c_hdr};
                            n_mi      = '0;
                            ram_re    = 1'b1;
                            ram_raddr = c_hdr;
                            c_busy    = 1'b1;
                            n_state   = S_MOVE;
                        end
                    end else if (c_scan >= c_fill || {1'b0, c_hdr} > c_scan) begin
                        c_fill = '0;
                        c_scan = '0;
                        c_hdr  = '0;
                        c_inp  = 1'b0;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = c_scan[AW-1:0];
                        c_busy    = 1'b1;
                        n_state   = S_CHAR;
                    end
                end

                n_fill  = c_fill;
                n_scan  = c_scan;
                n_hdr   = c_hdr;
                n_inp   = c_inp;
                n_taken = c_taken;
                if (!c_busy) begin
                    n_state = c_taken ? S_FINISH : S_ITER;
                end
            end

            S_CHAR: begin
                if (!r_inp) begin
                    if (rd_eff == CH_DOLLAR) begin
                        n_hdr = r_scan[AW-1:0];
                        n_inp = 1'b1;
                    end
                    n_scan  = r_scan + CW'(1);
                    n_state = r_taken ? S_FINISH : S_ITER;
                end else if (rd_eff != CH_NL) begin
                    n_scan  = r_scan + CW'(1);
                    n_state = r_taken ? S_FINISH : S_ITER;
                end else begin
                    // newline: scan stays on it while the checksum is walked
                    n_inp = 1'b0;
                    len_c = r_scan - {1'b0, r_hdr} + CW'(1);
                    n_len = len_c;
                    n_k   = CW'(1);
                    n_sum = CH_NUL;
                    if (len_c > CW'(1)) begin
                        ram_re    = 1'b1;
                        ram_raddr = r_hdr + AW'(1);
                        n_state   = S_WCHK;
                    end else begin
                        n_scan  = {1'b0, r_hdr} + CW'(1);
                        n_state = r_taken ? S_FINISH : S_ITER;
                    end
                end
            end

            S_WCHK: begin
                if (rd_eff == CH_STAR) begin
                    if (r_k + CW'(2) < r_len) begin
                        ram_re    = 1'b1;
                        ram_raddr = AW'({1'b0, r_hdr} + r_k + CW'(1));
                        n_state   = S_D1;
                    end else begin
                        n_scan  = {1'b0, r_hdr} + CW'(1);
                        n_state = r_taken ? S_FINISH : S_ITER;
                    end
                end else begin
                    n_sum = r_sum ^ rd_eff;
                    k1    = r_k + CW'(1);
                    n_k   = k1;
                    if (k1 < r_len) begin
                        ram_re    = 1'b1;
                        ram_raddr = AW'({1'b0, r_hdr} + k1);
                    end else begin
                        // no '*' before the newline
                        n_scan  = {1'b0, r_hdr} + CW'(1);
                        n_state = r_taken ? S_FINISH : S_ITER;
                    end
                end
            end

            S_D1: begin
                n_ok      = (rd_eff == hex_ascii(r_sum[7:4]));
                ram_re    = 1'b1;
                ram_raddr = AW'({1'b0, r_hdr} + r_k + CW'(2));
                n_state   = S_D2;
            end

            S_D2: begin
                if (r_ok && rd_eff == hex_ascii(r_sum[3:0])) begin
                    ram_we      = 1'b1;
                    ram_waddr   = r_scan[AW-1:0];
                    ram_wdata   = CH_NUL;
                    n_res_found = 1'b1;
                    n_res_start = 7'(r_hdr);
                    n_res_len   = 8'(r_len);
                end else begin
                    n_scan = {1'b0, r_hdr} + CW'(1);
                end
                n_state = r_taken ? S_FINISH : S_ITER;
            end

            S_MOVE: begin
                ram_we    = 1'b1;
                ram_waddr = r_mi[AW-1:0];
                ram_wdata = rd_eff;
                k1        = r_mi + CW'(1);
                if (k1 < r_fill) begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'({1'b0, r_hdr} + k1);
                    n_mi      = k1;
                end else begin
                    n_hdr   = '0;
                    n_state = r_taken ? S_FINISH : S_ITER;
                end
            end

            S_FINISH: begin
                if (!r_out_valid || o_out_ch.ready) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_res_found;
                    n_out_start = r_res_start;
                    n_out_len   = r_res_len;
                    n_out_rdata = r_res_rdata;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_scan      <= '0;
            r_hdr       <= '0;
            r_inp       <= 1'b0;
            r_taken     <= 1'b0;
            r_fwd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_scan      <= n_scan;
            r_hdr       <= n_hdr;
            r_inp       <= n_inp;
            r_taken     <= n_taken;
            r_fwd       <= n_fwd;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte      <= n_byte;
        r_k         <= n_k;
        r_len       <= n_len;
        r_sum       <= n_sum;
        r_ok        <= n_ok;
        r_mi        <= n_mi;
        r_rd_sel    <= n_rd_sel;
        r_fwd_data  <= n_fwd_data;
        r_res_found <= n_res_found;
        r_res_start <= n_res_start;
        r_res_len   <= n_res_len;
        r_res_rdata <= n_res_rdata;
        r_out_found <= n_out_found;
        r_out_start <= n_out_start;
        r_out_len   <= n_out_len;
        r_out_rdata <= n_out_rdata;
    end
endmodule

FILE: rtl/core/nmsf_checker.sv
// nmsf_checker: port-level assertions for the nmea sentence framer
// bound to nmea_sentence_framer; needs its channel interfaces
module nmsf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_frame_found,
    input logic [6:0] i_frame_start,
    input logic [7:0] i_frame_length,
    input logic [7:0] i_read_data
);
    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_frame_found) && $stable(i_frame_start) &&
            $stable(i_frame_length) && $stable(i_read_data))
        else $error("result changed while stalled");

    // one item in work at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second item taken while busy");

    a_no_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_frame_found |-> i_frame_start == 7'd0 && i_frame_length == 8'd0)
        else $error("frame position without a frame");

    a_frame_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_frame_found |-> i_read_data == 8'd0)
        else $error("read data on a push result");
endmodule

bind nmea_sentence_framer nmsf_checker u_nmsf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_ch.valid),
    .i_in_ready     (i_in_ch.ready),
    .i_out_valid    (o_out_ch.valid),
    .i_out_ready    (o_out_ch.ready),
    .i_frame_found  (o_out_ch.frame_found),
    .i_frame_start  (o_out_ch.frame_start),
    .i_frame_length (o_out_ch.frame_length),
    .i_read_data    (o_out_ch.read_data)
);
